FILE: rtl/humidity_temp_frame_decoder_assert.svh
// Assertion macros shared by the frame decoder RTL.
// Expects a clock named clock and an active-high synchronous reset named reset in scope.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define HTFD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define HTFD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent
`define HTFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/htfd_pkg.sv
// Types, constants and conversion functions for the humidity/temperature frame decoder.
// No dependencies; imported by htfd_frame and humidity_temp_frame_decoder.
package htfd_pkg;

   // Byte positions within the six-byte reply
   localparam logic [2:0] POS_T_MSB = 3'd0;
   localparam logic [2:0] POS_T_LSB = 3'd1;
   localparam logic [2:0] POS_T_CRC = 3'd2;
   localparam logic [2:0] POS_H_MSB = 3'd3;
   localparam logic [2:0] POS_H_LSB = 3'd4;
   localparam logic [2:0] POS_H_CRC = 3'd5;

   // CRC-8 settings
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_MSB  = 8'h80;

   // Full-scale spans in hundredths and offsets
   localparam logic [14:0] SPAN_C    = 15'd17500;
   localparam logic [14:0] SPAN_F    = 15'd31500;
   localparam logic [14:0] SPAN_H    = 15'd10000;
   localparam logic [15:0] OFFS_C    = 16'd4500;
   localparam logic [15:0] OFFS_F    = 16'd4900;
   localparam logic [31:0] WORD_FULL = 32'd65535;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic signed [14:0] temp_centi_c;
      logic signed [15:0] temp_centi_f;
      logic [13:0]        humidity_centi_pct;
      logic               temp_word_ok;
      logic               hum_word_ok;
   } rsp_type;

   // Status of the transaction held in the input register
   typedef struct packed {
      logic    last_byte;
      rsp_type result;
   } frame_stat_type;

   // One byte through the CRC-8 register, MSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((r & CRC_MSB) != 8'd0) begin
            r = {r[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

   // floor(raw * span / 65535): reciprocal estimate, then one compare and correct
   function automatic logic [14:0] scale_word(input logic [15:0] raw, input logic [14:0] span);
      logic [30:0] prod;
      logic [31:0] est;
      logic [15:0] quo;
      logic [31:0] rem;
      prod = raw * span;
      est  = {1'b0, prod} + {17'd0, prod[30:16]} + 32'd1;
      quo  = est[31:16];
      rem  = {1'b0, prod} - ({quo, 16'd0} - {16'd0, quo});
      if (rem >= WORD_FULL) begin
         quo = quo + 16'd1;
      end
      return quo[14:0];
   endfunction

endpackage

FILE: rtl/htfd_frame.sv
// Frame tracker: byte position, running CRC, captured words and unit conversions.
// Depends on htfd_pkg and humidity_temp_frame_decoder_assert.svh.
`include "humidity_temp_frame_decoder_assert.svh"

module htfd_frame
   import htfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  req_type        item,
   input  logic           commit,
   output frame_stat_type stat
);

   logic [2:0]         pos_ff, pos_in;
   logic [7:0]         crc_ff, crc_in;
   logic [15:0]        temp_raw_ff, temp_raw_in;
   logic [7:0]         hum_high_ff, hum_high_in;
   logic [7:0]         hum_low_ff, hum_low_in;
   logic               temp_ok_ff, temp_ok_in;
   logic signed [14:0] temp_c_ff, temp_c_in;
   logic signed [15:0] temp_f_ff, temp_f_in;

   logic [2:0]  eff_pos;
   logic [7:0]  crc_base;
   logic [7:0]  crc_next;
   logic [14:0] q_c;
   logic [14:0] q_f;
   logic [14:0] q_h;
   logic [15:0] diff_c;
   logic [15:0] diff_f;

   // Resolve the position of this transaction's byte
   always_comb begin
      if (item.frame_start || (pos_ff > POS_H_CRC)) begin
         eff_pos = POS_T_MSB;
      end else begin
         eff_pos = pos_ff;
      end
   end

   // Restart the CRC at the head of each group
   assign crc_base = ((eff_pos == POS_T_MSB) || (eff_pos == POS_H_MSB)) ? CRC_INIT : crc_ff;
   assign crc_next = crc8_byte(crc_base, item.rx_byte);

   // Convert the stored words to hundredths
   assign q_c    = scale_word(temp_raw_ff, SPAN_C);
   assign q_f    = scale_word(temp_raw_ff, SPAN_F);
   assign q_h    = scale_word({hum_high_ff, hum_low_ff}, SPAN_H);
   assign diff_c = {1'b0, q_c} - OFFS_C;
   assign diff_f = {1'b0, q_f} - OFFS_F;

   // Advance the frame state on each committed transaction
   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      temp_raw_in = temp_raw_ff;
      hum_high_in = hum_high_ff;
      hum_low_in  = hum_low_ff;
      temp_ok_in  = temp_ok_ff;
      temp_c_in   = temp_c_ff;
      temp_f_in   = temp_f_ff;
      if (commit) begin
         crc_in = crc_next;
         pos_in = (eff_pos >= POS_H_CRC) ? POS_T_MSB : eff_pos + 3'd1;
         case (eff_pos)
            POS_T_MSB: begin
               temp_raw_in = {item.rx_byte, 8'd0};
            end
            POS_T_LSB: begin
               temp_raw_in = {temp_raw_ff[15:8], item.rx_byte};
            end
            POS_T_CRC: begin
               temp_ok_in = (crc_next == 8'd0);
               temp_c_in  = diff_c[14:0];
               temp_f_in  = diff_f;
            end
            POS_H_MSB: begin
               hum_high_in = item.rx_byte;
            end
            POS_H_LSB: begin
               hum_low_in = item.rx_byte;
            end
            default: begin
            end
         endcase
      end
   end

   // Present the result for the final byte of a frame
   always_comb begin
      stat.last_byte                 = (eff_pos == POS_H_CRC);
      stat.result.temp_centi_c       = temp_c_ff;
      stat.result.temp_centi_f       = temp_f_ff;
      stat.result.humidity_centi_pct = q_h[13:0];
      stat.result.temp_word_ok       = temp_ok_ff;
      stat.result.hum_word_ok        = (crc_next == 8'd0);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_T_MSB;
         crc_ff      <= CRC_INIT;
         temp_raw_ff <= 16'd0;
         hum_high_ff <= 8'd0;
         hum_low_ff  <= 8'd0;
         temp_ok_ff  <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         temp_raw_ff <= temp_raw_in;
         hum_high_ff <= hum_high_in;
         hum_low_ff  <= hum_low_in;
         temp_ok_ff  <= temp_ok_in;
      end
   end

   // Converted temperature, loaded after the temperature CRC byte
   always_ff @(posedge clock) begin
      temp_c_ff <= temp_c_in;
      temp_f_ff <= temp_f_in;
   end

   `HTFD_ASSERT_ALWAYS(a_pos_range, pos_ff <= POS_H_CRC, "frame position out of range")
   `HTFD_ASSERT_NEXT(a_wrap, commit && stat.last_byte, pos_ff == POS_T_MSB, "no wrap after last byte")
   `HTFD_ASSERT_NEXT(a_temp_flag, commit && (eff_pos == POS_T_CRC), temp_ok_ff == (crc_ff == 8'd0), "temperature CRC flag mismatch")

endmodule

FILE: rtl/humidity_temp_frame_decoder.sv
// Top level of the humidity/temperature frame decoder: input and result registers.
// Depends on htfd_pkg, htfd_frame and humidity_temp_frame_decoder_assert.svh.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_ready  | req_data (req_type)
//   rsp_    | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//
// One byte per cycle unless a result stalls; each result goes from input register to result register.
// The input register feeds the CRC update and constant scaling; the result register holds output.
// Reset clears the frame position to the first byte and the CRC to 0xFF; no clearing pass.
// A stalled result blocks only the sixth byte of the next frame; other bytes keep flowing.
`include "humidity_temp_frame_decoder_assert.svh"

module humidity_temp_frame_decoder
   import htfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   req_type        in_ff, in_in;
   logic           in_valid_ff, in_valid_in;
   rsp_type        out_ff, out_in;
   logic           out_valid_ff, out_valid_in;
   logic           out_free;
   logic           advance;
   frame_stat_type stat;

   htfd_frame u_frame (
      .clock  (clock),
      .reset  (reset),
      .item   (in_ff),
      .commit (advance),
      .stat   (stat)
   );

   // Move the held transaction on unless its result has nowhere to go
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!stat.last_byte || out_free);
   assign req_ready = !in_valid_ff || advance;

   // Next values of the two registers
   always_comb begin
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
      in_in        = (req_valid && req_ready) ? req_data : in_ff;
      out_valid_in = (advance && stat.last_byte) || (out_valid_ff && !rsp_ready);
      out_in       = (advance && stat.last_byte) ? stat.result : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `HTFD_ASSERT_SAME(a_no_overwrite, advance && stat.last_byte, out_free, "pending result overwritten")
   `HTFD_ASSERT_NEXT(a_result_shown, advance && stat.last_byte, out_valid_ff, "result lost")
   `HTFD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

endmodule

FILE: tb/htfd_reading_checker.sv
// Scoreboard for the humidity/temperature frame decoder: predicts each reading and compares it.
// Depends on htfd_pkg for the transaction types, positions and CRC/scaling constants.
package htfd_tb_pkg;
   import htfd_pkg::*;

   // Advance a CRC-8 (poly 0x31, MSB first) by one byte
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      repeat (8) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
      end
      return r;
   endfunction
endpackage

module htfd_reading_checker
   import htfd_pkg::*;
   import htfd_tb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      due_count,
   output int      checked_count
);

   // Shadow of the decoder state
   logic [2:0]  next_pos;
   logic [7:0]  crc_acc;
   logic [15:0] temp_word;
   logic [7:0]  hum_msb;
   logic [7:0]  hum_lsb;
   logic        temp_ok;

   rsp_type     readings_due[$];
   int          fails = 0;
   int          checked = 0;

   // floor(raw * span / 65535), exact
   function automatic int scale_centi(input logic [15:0] raw, input int span);
      longint p;
      p = longint'(raw) * span;
      return int'(p / 65535);
   endfunction

   // Apply one received byte to the shadow state; queue a reading after the sixth
   task automatic decode_byte(input req_type t);
      logic [2:0] pos;
      logic [7:0] crc_in;
      logic [7:0] crc_out;
      rsp_type    r;
      pos = t.frame_start ? POS_T_MSB : next_pos;
      if (pos > POS_H_CRC) pos = POS_T_MSB;
      crc_in  = (pos == POS_T_MSB || pos == POS_H_MSB) ? CRC_INIT : crc_acc;
      crc_out = crc8_update(crc_in, t.rx_byte);
      crc_acc = crc_out;
      case (pos)
         POS_T_MSB: temp_word = {t.rx_byte, 8'h00};
         POS_T_LSB: temp_word[7:0] = t.rx_byte;
         POS_T_CRC: temp_ok = (crc_out == 8'h00);
         POS_H_MSB: hum_msb = t.rx_byte;
         POS_H_LSB: hum_lsb = t.rx_byte;
         default: begin
            r.temp_centi_c       = 15'(scale_centi(temp_word, SPAN_C) - int'(OFFS_C));
            r.temp_centi_f       = 16'(scale_centi(temp_word, SPAN_F) - int'(OFFS_F));
            r.humidity_centi_pct = 14'(scale_centi({hum_msb, hum_lsb}, SPAN_H));
            r.temp_word_ok       = temp_ok;
            r.hum_word_ok        = (crc_out == 8'h00);
            readings_due.push_back(r);
         end
      endcase
      next_pos = (pos >= POS_H_CRC) ? POS_T_MSB : pos + 3'd1;
   endtask

   // Compare results first, then predict from the input transaction of the same edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         next_pos  = POS_T_MSB;
         crc_acc   = CRC_INIT;
         temp_word = '0;
         hum_msb   = '0;
         hum_lsb   = '0;
         temp_ok   = 1'b0;
         readings_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               $error("unexpected reading %h with none due", rsp_data);
               fails++;
            end else begin
               want = readings_due.pop_front();
               checked++;
               if (rsp_data.temp_centi_c !== want.temp_centi_c) begin
                  $error("temp_centi_c expected %0d actual %0d",
                         want.temp_centi_c, rsp_data.temp_centi_c);
                  fails++;
               end
               if (rsp_data.temp_centi_f !== want.temp_centi_f) begin
                  $error("temp_centi_f expected %0d actual %0d",
                         want.temp_centi_f, rsp_data.temp_centi_f);
                  fails++;
               end
               if (rsp_data.humidity_centi_pct !== want.humidity_centi_pct) begin
                  $error("humidity_centi_pct expected %0d actual %0d",
                         want.humidity_centi_pct, rsp_data.humidity_centi_pct);
                  fails++;
               end
               if (rsp_data.temp_word_ok !== want.temp_word_ok) begin
                  $error("temp_word_ok expected %0b actual %0b",
                         want.temp_word_ok, rsp_data.temp_word_ok);
                  fails++;
               end
               if (rsp_data.hum_word_ok !== want.hum_word_ok) begin
                  $error("hum_word_ok expected %0b actual %0b",
                         want.hum_word_ok, rsp_data.hum_word_ok);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready) decode_byte(req_data);
      end
      fail_count    <= fails;
      due_count     <= readings_due.size();
      checked_count <= checked;
   end

endmodule

FILE: tb/tb_humidity_temp_frame_decoder.sv
// Top of the frame decoder bench: clock, reset, byte stimulus and receiver stalls.
// Depends on htfd_pkg, htfd_tb_pkg and htfd_reading_checker; instantiates the decoder as uut.
module tb_humidity_temp_frame_decoder;
   import htfd_pkg::*;
   import htfd_tb_pkg::*;

   localparam int RUN_BYTES   = 450;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int due_count;
   int checked_count;
   int cycle_count   = 0;
   int bytes_sent    = 0;
   int frames_sent   = 0;
   int broken_bursts = 0;
   int burst_left    = 0;

   // Receiver stall pattern
   int       stall_mode = 0;
   int       mode_left  = 0;
   int       hold_left  = 0;

   humidity_temp_frame_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   htfd_reading_checker reading_chk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .due_count     (due_count),
      .checked_count (checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run aborted after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // Switch between always-ready, coin-toss, long-stall and rare-stall modes
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(20, 120);
      end else begin
         mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: begin
               if ($urandom_range(0, 5) == 0) begin
                  hold_left <= $urandom_range(1, 12);
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Offer one byte, inserting a random gap between bursts
   task automatic send_byte(input logic [7:0] value, input logic start);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
      end
      req_data  <= '{rx_byte: value, frame_start: start};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      burst_left--;
   endtask

   // Hold off the sender until every due reading has arrived
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   // Send a six-byte reply; spoil[0] and spoil[1] corrupt the temperature and humidity CRC
   task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                             input logic start, input logic [1:0] spoil);
      logic [7:0] t_crc;
      logic [7:0] h_crc;
      t_crc = crc8_update(crc8_update(CRC_INIT, t_word[15:8]), t_word[7:0]);
      h_crc = crc8_update(crc8_update(CRC_INIT, h_word[15:8]), h_word[7:0]);
      if (spoil[0]) t_crc ^= 8'($urandom_range(1, 255));
      if (spoil[1]) h_crc ^= 8'($urandom_range(1, 255));
      send_byte(t_word[15:8], start);
      send_byte(t_word[7:0], 1'b0);
      send_byte(t_crc, 1'b0);
      send_byte(h_word[15:8], 1'b0);
      send_byte(h_word[7:0], 1'b0);
      send_byte(h_crc, 1'b0);
      frames_sent++;
   endtask

   // Raw word with the scale ends favoured
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      logic need_start;
      int   kind;
      int   n;
      need_start = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Scale ends, back-to-back frames, a dropped partial frame, failed CRCs
      send_frame(16'h0000, 16'h0000, 1'b1, 2'b00);
      send_frame(16'hFFFF, 16'hFFFF, 1'b0, 2'b00);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h5A, 1'b0);
      send_frame(16'h6666, 16'h8000, 1'b1, 2'b01);
      send_frame(16'h8000, 16'h1234, 1'b0, 2'b10);
      wait_idle();

      // Mostly well-formed frames, with partial bursts and stray frame starts
      while (bytes_sent < RUN_BYTES) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            n = $urandom_range(1, 5);
            repeat (n) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            broken_bursts++;
            need_start = 1'b1;
         end else begin
            send_frame(pick_word(), pick_word(), need_start | 1'($urandom_range(0, 1)),
                       ($urandom_range(0, 5) == 0) ? 2'($urandom_range(1, 3)) : 2'b00);
            need_start = 1'b0;
         end
         if ($urandom_range(0, 24) == 0) wait_idle();
      end
      wait_idle();

      $display("Drove %0d bytes: %0d whole frames and %0d partial or resynchronising bursts",
               bytes_sent, frames_sent, broken_bursts);
      $display("Compared %0d readings with the prediction", checked_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
